@@ design/tbgd_pkg.sv @@
package tbgd_pkg;

   // event codes
   localparam logic [3:0] EV_NONE        = 4'd0;
   localparam logic [3:0] EV_A_PRESS     = 4'd1;
   localparam logic [3:0] EV_A_TAP       = 4'd2;
   localparam logic [3:0] EV_MODE_NEXT   = 4'd3;
   localparam logic [3:0] EV_A_RELEASE   = 4'd4;
   localparam logic [3:0] EV_A_HOLD      = 4'd5;
   localparam logic [3:0] EV_B_PRESS     = 4'd6;
   localparam logic [3:0] EV_B_TAP       = 4'd7;
   localparam logic [3:0] EV_B_RELEASE   = 4'd8;
   localparam logic [3:0] EV_B_HOLD      = 4'd9;
   localparam logic [3:0] EV_MENU_TOGGLE = 4'd10;
   localparam logic [3:0] EV_GATE_RISE   = 4'd11;
   localparam logic [3:0] EV_GATE_FALL   = 4'd12;

   localparam int unsigned STAMP_W  = 32;
   localparam int unsigned THRESH_W = 16;
   localparam logic [THRESH_W-1:0] HOLD_THRESHOLD_RESET = 16'd500;

   // one input sample
   typedef struct packed {
      logic [STAMP_W-1:0] now_ms;
      logic               button_a_level;
      logic               button_b_level;
      logic               gate_level;
   } sample_type;

   // one result
   typedef struct packed {
      logic [3:0] event_code;
      logic       a_is_pressed;
      logic       b_is_pressed;
      logic       a_is_holding;
      logic       b_is_holding;
   } result_type;

   // detector state carried from sample to sample
   typedef struct packed {
      logic               a_last;
      logic               b_last;
      logic               g_last;
      logic               a_hold;
      logic               b_hold;
      logic               b_touched;
      logic               compound_done;
      logic [STAMP_W-1:0] a_stamp;
      logic [STAMP_W-1:0] b_stamp;
   } state_type;

endpackage

@@ design/tbgd_channel_if.sv @@
// sample channel
interface tbgd_req_if;
   logic                           valid;
   logic                           ready;
   logic [tbgd_pkg::STAMP_W-1:0]   now_ms;
   logic                           button_a_level;
   logic                           button_b_level;
   logic                           gate_level;

   modport source (output valid, output now_ms, output button_a_level,
                   output button_b_level, output gate_level, input ready);
   modport sink   (input valid, input now_ms, input button_a_level,
                   input button_b_level, input gate_level, output ready);
endinterface

// result channel
interface tbgd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] event_code;
   logic       a_is_pressed;
   logic       b_is_pressed;
   logic       a_is_holding;
   logic       b_is_holding;

   modport source (output valid, output event_code, output a_is_pressed,
                   output b_is_pressed, output a_is_holding, output b_is_holding,
                   input ready);
   modport sink   (input valid, input event_code, input a_is_pressed,
                   input b_is_pressed, input a_is_holding, input b_is_holding,
                   output ready);
endinterface

@@ design/tbgd_step.sv @@
module tbgd_step (
   input  tbgd_pkg::state_type                   state,
   input  logic [tbgd_pkg::THRESH_W-1:0]         hold_threshold,
   input  tbgd_pkg::sample_type                  sample,
   output tbgd_pkg::state_type                   state_next,
   output tbgd_pkg::result_type                  result
);

   logic                          a, b, g;
   logic [tbgd_pkg::STAMP_W-1:0]  a_age, b_age;
   logic [tbgd_pkg::STAMP_W-1:0]  thresh_ext;
   logic                          a_due, b_due;
   logic [3:0]                    ev;
   tbgd_pkg::state_type           st;

   assign a = sample.button_a_level;
   assign b = sample.button_b_level;
   assign g = sample.gate_level;

   // time since press, wrapping subtract
   assign thresh_ext = {{(tbgd_pkg::STAMP_W-tbgd_pkg::THRESH_W){1'b0}}, hold_threshold};
   assign a_age = sample.now_ms - state.a_stamp;
   assign b_age = sample.now_ms - state.b_stamp;
   assign a_due = (a_age >= thresh_ext);
   assign b_due = (b_age >= thresh_ext);

   // prioritized event and state update
   always_comb begin
      st = state;
      ev = tbgd_pkg::EV_NONE;

      // button a
      if (a && !state.a_last) begin
         st.a_stamp   = sample.now_ms;
         st.a_hold    = 1'b0;
         st.b_touched = 1'b0;
         ev           = tbgd_pkg::EV_A_PRESS;
      end else if (!a && state.a_last) begin
         if (!state.a_hold) begin
            ev = tbgd_pkg::EV_A_TAP;
         end else if (!state.b_touched && !state.compound_done) begin
            ev = tbgd_pkg::EV_MODE_NEXT;
         end else begin
            ev = tbgd_pkg::EV_A_RELEASE;
         end
         st.a_hold = 1'b0;
      end else if (a && !state.a_hold && a_due) begin
         st.a_hold = 1'b1;
         if (!b) begin
            ev = tbgd_pkg::EV_A_HOLD;
         end
      end

      // button b, only reported when a is quiet
      if (b && !state.b_last) begin
         st.b_stamp = sample.now_ms;
         st.b_hold  = 1'b0;
         if (st.a_hold) begin
            st.b_touched = 1'b1;
         end
         if (ev == tbgd_pkg::EV_NONE) begin
            ev = tbgd_pkg::EV_B_PRESS;
         end
      end else if (!b && state.b_last) begin
         if (ev == tbgd_pkg::EV_NONE) begin
            ev = state.b_hold ? tbgd_pkg::EV_B_RELEASE : tbgd_pkg::EV_B_TAP;
         end
         st.b_hold = 1'b0;
      end else if (b && !state.b_hold && b_due) begin
         st.b_hold = 1'b1;
         if (ev == tbgd_pkg::EV_NONE) begin
            ev = tbgd_pkg::EV_B_HOLD;
         end
      end

      // compound gesture: b hold while an earlier a is down
      if (!state.compound_done && ev == tbgd_pkg::EV_B_HOLD && a
          && (st.a_stamp < st.b_stamp)) begin
         ev               = tbgd_pkg::EV_MENU_TOGGLE;
         st.compound_done = 1'b1;
      end
      if (!a && !b) begin
         st.compound_done = 1'b0;
      end

      // gate edges fill in when no button event
      if (ev == tbgd_pkg::EV_NONE) begin
         if (g && !state.g_last) begin
            ev = tbgd_pkg::EV_GATE_RISE;
         end else if (!g && state.g_last) begin
            ev = tbgd_pkg::EV_GATE_FALL;
         end
      end

      st.a_last = a;
      st.b_last = b;
      st.g_last = g;
   end

   assign state_next          = st;
   assign result.event_code   = ev;
   assign result.a_is_pressed = a;
   assign result.b_is_pressed = b;
   assign result.a_is_holding = st.a_hold;
   assign result.b_is_holding = st.b_hold;

endmodule

@@ design/two_button_gesture_detector_unit.sv @@
// Two-button gesture detector. Each sample transaction (millisecond time,
// button A and B levels, gate level) yields exactly one result transaction
// carrying the highest-priority event of that sample (A events over B events
// over gate edges) together with the pressed and holding flags. Samples are
// captured in an input register and evaluated combinationally into the result
// register, so one sample is taken every clock while the result channel keeps
// taking results; result valid rises once the accepted sample has passed from
// the input register into the result register. The state update is
// combinational (one 32-bit subtract and compare per button). The hold
// threshold (reset 500 ms) is written through csr_wr_en/csr_wr_data; the user
// must write it while no sample is in flight, as the block does not enforce it.
module two_button_gesture_detector_unit (
   input  logic                           clock,
   input  logic                           reset,
   tbgd_req_if.sink                       req_ch,
   tbgd_rsp_if.source                     rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [tbgd_pkg::THRESH_W-1:0]  csr_wr_data
);

   logic                          in_valid_ff, in_valid_in;
   tbgd_pkg::sample_type          in_sample_ff;
   logic                          out_valid_ff, out_valid_in;
   tbgd_pkg::result_type          out_result_ff;
   tbgd_pkg::state_type           state_ff, state_in;
   tbgd_pkg::result_type          step_result;
   logic [tbgd_pkg::THRESH_W-1:0] thresh_ff;
   logic                          advance;
   logic                          req_take;

   // pipeline handshake
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   // gesture evaluation
   tbgd_step u_step (
      .state          (state_ff),
      .hold_threshold (thresh_ff),
      .sample         (in_sample_ff),
      .state_next     (state_in),
      .result         (step_result)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         thresh_ff    <= tbgd_pkg::HOLD_THRESHOLD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff.now_ms         <= req_ch.now_ms;
         in_sample_ff.button_a_level <= req_ch.button_a_level;
         in_sample_ff.button_b_level <= req_ch.button_b_level;
         in_sample_ff.gate_level     <= req_ch.gate_level;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.event_code   = out_result_ff.event_code;
   assign rsp_ch.a_is_pressed = out_result_ff.a_is_pressed;
   assign rsp_ch.b_is_pressed = out_result_ff.b_is_pressed;
   assign rsp_ch.a_is_holding = out_result_ff.a_is_holding;
   assign rsp_ch.b_is_holding = out_result_ff.b_is_holding;

   // event code stays within the defined codes
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.event_code <= tbgd_pkg::EV_GATE_FALL))
      else $error("event code out of range");

   // a holding flag is never reported for a released button
   a_hold_pressed: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((!rsp_ch.a_is_holding || rsp_ch.a_is_pressed)
                        && (!rsp_ch.b_is_holding || rsp_ch.b_is_pressed)))
      else $error("holding flag without pressed button");

   // menu toggle needs both buttons down and b holding
   a_menu_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.event_code == tbgd_pkg::EV_MENU_TOGGLE)
      |-> (rsp_ch.a_is_pressed && rsp_ch.b_is_pressed && rsp_ch.b_is_holding))
      else $error("menu toggle with wrong button state");

   // mode next only on a release of a
   a_mode_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.event_code == tbgd_pkg::EV_MODE_NEXT)
      |-> (!rsp_ch.a_is_pressed && !rsp_ch.a_is_holding))
      else $error("mode next while a still down");

   // an advance always leaves a result waiting
   a_advance_valid: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result lost after advance");

endmodule
